>>> rtl/core/pfra_pkg.sv
`timescale 1ns / 1ps

package pfra_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned FREE_W     = 12;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned FRAME_W    = ADDR_W - PAGE_SHIFT;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0]      USED_MARK = 8'd100;
  localparam logic [CNT_W-1:0]      CNT_MAX   = 8'd255;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET_VALUE = 32'd1048576;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_SHARE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOMEM       = 3'd1,
    ST_IGNORED     = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_SATURATED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_PREP,
    S_INIT_SWEEP,
    S_SCAN,
    S_RMW_CHK,
    S_RMW_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic init_prep;
    logic init_step;
    logic scan_step;
    logic rmw_chk;
    logic rmw_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic scan_hit;
    logic scan_miss;
    logic slot_free;
  } sts_t;

endpackage

>>> rtl/core/pfra_if.sv
`timescale 1ns / 1ps

interface pfra_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [pfra_pkg::ADDR_W-1:0] page_address;

  modport source (output valid, output opcode, output page_address, input ready);
  modport sink (input valid, input opcode, input page_address, output ready);
endinterface

interface pfra_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pfra_pkg::ADDR_W-1:0] result_address;
  logic [2:0]                  status;
  logic [pfra_pkg::FREE_W-1:0] free_count;

  modport source (output valid, output result_address, output status, output free_count,
                  input ready);
  modport sink (input valid, input result_address, input status, input free_count,
                output ready);
endinterface

>>> rtl/core/pfra_ctrl.sv
`timescale 1ns / 1ps

module pfra_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  pfra_pkg::op_t    in_opcode,
  output logic             in_ready,
  output pfra_pkg::cmd_t   cmd,
  input  pfra_pkg::sts_t   sts
);

  pfra_pkg::state_t state_r;
  pfra_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfra_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfra_pkg::S_CLEAR: begin
        if (sts.sweep_last) state_nxt = pfra_pkg::S_IDLE;
      end
      pfra_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            pfra_pkg::OP_INIT:  state_nxt = pfra_pkg::S_INIT_PREP;
            pfra_pkg::OP_ALLOC: state_nxt = pfra_pkg::S_SCAN;
            default:            state_nxt = pfra_pkg::S_RMW_CHK;
          endcase
        end
      end
      pfra_pkg::S_INIT_PREP:  state_nxt = pfra_pkg::S_INIT_SWEEP;
      pfra_pkg::S_INIT_SWEEP: begin
        if (sts.sweep_last) state_nxt = pfra_pkg::S_DONE;
      end
      pfra_pkg::S_SCAN: begin
        if (sts.scan_hit || sts.scan_miss) state_nxt = pfra_pkg::S_DONE;
      end
      pfra_pkg::S_RMW_CHK: state_nxt = pfra_pkg::S_RMW_WR;
      pfra_pkg::S_RMW_WR:  state_nxt = pfra_pkg::S_DONE;
      pfra_pkg::S_DONE: begin
        if (sts.slot_free) state_nxt = pfra_pkg::S_IDLE;
      end
      default: state_nxt = pfra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      pfra_pkg::S_CLEAR:      cmd.clr_step = 1'b1;
      pfra_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      pfra_pkg::S_INIT_PREP:  cmd.init_prep = 1'b1;
      pfra_pkg::S_INIT_SWEEP: cmd.init_step = 1'b1;
      pfra_pkg::S_SCAN:       cmd.scan_step = 1'b1;
      pfra_pkg::S_RMW_CHK:    cmd.rmw_chk   = 1'b1;
      pfra_pkg::S_RMW_WR:     cmd.rmw_wr    = 1'b1;
      pfra_pkg::S_DONE:       cmd.out_load  = sts.slot_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/pfra_dp.sv
`timescale 1ns / 1ps

module pfra_dp #(
  parameter int unsigned PAGES        = 3840,
  parameter logic [31:0] BASE_ADDRESS = 32'd1048576
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pfra_pkg::cmd_t                    cmd,
  output pfra_pkg::sts_t                    sts,
  input  pfra_pkg::op_t                     in_opcode,
  input  logic [pfra_pkg::ADDR_W-1:0]       in_page_address,
  input  logic                              cfg_we,
  input  logic [pfra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfra_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [pfra_pkg::ADDR_W-1:0]       out_result_address,
  output pfra_pkg::status_t                 out_status,
  output logic [pfra_pkg::FREE_W-1:0]       out_free_count
);

  localparam int unsigned IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned SPAN_W = pfra_pkg::FRAME_W + 1;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(PAGES - 1);
  localparam logic [SPAN_W-1:0] PAGES_SPAN = SPAN_W'(PAGES);

  // configuration
  logic [pfra_pkg::ADDR_W-1:0] region_start_r;
  logic [pfra_pkg::ADDR_W-1:0] region_end_r;

  // count memory
  logic [pfra_pkg::CNT_W-1:0] count_mem [PAGES];
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_wa;
  logic [pfra_pkg::CNT_W-1:0] mem_wd;
  logic [IDX_W-1:0]           rd_addr;
  logic [pfra_pkg::CNT_W-1:0] rd_data_r;

  // request and sweep / scan state
  pfra_pkg::op_t               op_r;
  logic [pfra_pkg::ADDR_W-1:0] addr_r;
  logic [IDX_W-1:0]            sweep_idx_r;
  logic [IDX_W-1:0]            scan_idx_r;
  logic [IDX_W-1:0]            rd_idx_r;
  logic                        rd_pend_r;
  logic [IDX_W-1:0]            idx_r;
  logic                        range_ok_r;
  logic [pfra_pkg::FRAME_W-1:0] first_r;
  logic [pfra_pkg::FRAME_W-1:0] span_r;
  logic [SPAN_W-1:0]           stop_r;
  logic [pfra_pkg::FREE_W-1:0] free_r;
  logic [pfra_pkg::FREE_W-1:0] free_nxt;
  logic [pfra_pkg::ADDR_W-1:0] res_addr_r;
  pfra_pkg::status_t           res_status_r;

  logic                        out_valid_r;
  logic [pfra_pkg::ADDR_W-1:0] out_addr_r;
  pfra_pkg::status_t           out_status_r;
  logic [pfra_pkg::FREE_W-1:0] out_free_r;

  // combinational helpers
  logic [pfra_pkg::ADDR_W-1:0] start_off;
  logic [pfra_pkg::ADDR_W-1:0] region_len;
  logic [pfra_pkg::ADDR_W-1:0] page_off;
  logic                        in_range;
  logic [SPAN_W-1:0]           sweep_wide;
  logic                        in_region;
  logic                        scan_hit;
  logic                        scan_miss;
  logic                        slot_free;
  pfra_pkg::status_t           rmw_status;
  logic                        rmw_we;
  logic [pfra_pkg::CNT_W-1:0]  rmw_wd;
  logic                        rmw_inc;
  logic                        rmw_dec;

  assign start_off  = region_start_r - BASE_ADDRESS;
  assign region_len = region_end_r - region_start_r;
  assign page_off   = addr_r - BASE_ADDRESS;
  assign in_range   = (addr_r >= BASE_ADDRESS) && (addr_r <= region_end_r) &&
                      ({1'b0, page_off[pfra_pkg::ADDR_W-1:pfra_pkg::PAGE_SHIFT]} < PAGES_SPAN);

  assign sweep_wide = SPAN_W'(sweep_idx_r);
  assign in_region  = (sweep_wide >= {1'b0, first_r}) && (sweep_wide < stop_r);

  assign scan_hit   = cmd.scan_step && rd_pend_r && (rd_data_r == '0);
  assign scan_miss  = cmd.scan_step && rd_pend_r && (rd_data_r != '0) && (rd_idx_r == '0);
  assign slot_free  = !out_valid_r || out_ready;

  assign sts.sweep_last = (sweep_idx_r == LAST_IDX);
  assign sts.scan_hit   = scan_hit;
  assign sts.scan_miss  = scan_miss;
  assign sts.slot_free  = slot_free;

  // read-modify-write of one count for free and share
  always_comb begin
    rmw_status = pfra_pkg::ST_OK;
    rmw_we     = 1'b0;
    rmw_wd     = rd_data_r;
    rmw_inc    = 1'b0;
    rmw_dec    = 1'b0;
    if (!range_ok_r) begin
      rmw_status = pfra_pkg::ST_IGNORED;
    end else if (op_r == pfra_pkg::OP_FREE) begin
      if (rd_data_r == '0) begin
        rmw_status = pfra_pkg::ST_DOUBLE_FREE;
      end else begin
        rmw_we  = 1'b1;
        rmw_wd  = rd_data_r - 8'd1;
        rmw_inc = (rd_data_r == 8'd1);
      end
    end else begin
      if (rd_data_r == pfra_pkg::CNT_MAX) begin
        rmw_status = pfra_pkg::ST_SATURATED;
      end else begin
        rmw_we  = 1'b1;
        rmw_wd  = rd_data_r + 8'd1;
        rmw_dec = (rd_data_r == '0);
      end
    end
  end

  // memory write port select
  always_comb begin
    mem_we = 1'b0;
    mem_wa = sweep_idx_r;
    mem_wd = pfra_pkg::USED_MARK;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.init_step) begin
      mem_we = 1'b1;
      mem_wd = in_region ? '0 : pfra_pkg::USED_MARK;
    end else if (scan_hit) begin
      mem_we = 1'b1;
      mem_wa = rd_idx_r;
      mem_wd = 8'd1;
    end else if (cmd.rmw_wr) begin
      mem_we = rmw_we;
      mem_wa = idx_r;
      mem_wd = rmw_wd;
    end
  end

  assign rd_addr = cmd.scan_step ? scan_idx_r
                                 : page_off[pfra_pkg::PAGE_SHIFT +: IDX_W];

  always_ff @(posedge clk) begin
    if (mem_we) count_mem[mem_wa] <= mem_wd;
    rd_data_r <= count_mem[rd_addr];
  end

  always_comb begin
    free_nxt = free_r;
    if (cmd.init_prep) begin
      free_nxt = '0;
    end else if (cmd.init_step && in_region) begin
      free_nxt = free_r + 12'd1;
    end else if (scan_hit || (cmd.rmw_wr && rmw_dec)) begin
      free_nxt = free_r - 12'd1;
    end else if (cmd.rmw_wr && rmw_inc) begin
      free_nxt = free_r + 12'd1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= pfra_pkg::CFG_RESET_VALUE;
      region_end_r   <= pfra_pkg::CFG_RESET_VALUE;
      sweep_idx_r    <= '0;
      rd_pend_r      <= 1'b0;
      free_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pfra_pkg::CFG_REGION_START: region_start_r <= cfg_wdata;
          pfra_pkg::CFG_REGION_END:   region_end_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.init_prep) begin
        sweep_idx_r <= '0;
      end else if (cmd.clr_step || cmd.init_step) begin
        sweep_idx_r <= sweep_idx_r + 1'b1;
      end
      if (cmd.accept) begin
        rd_pend_r <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_pend_r <= 1'b1;
      end
      free_r <= free_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= in_opcode;
      addr_r       <= in_page_address;
      scan_idx_r   <= LAST_IDX;
      first_r      <= start_off[pfra_pkg::ADDR_W-1:pfra_pkg::PAGE_SHIFT];
      span_r       <= region_len[pfra_pkg::ADDR_W-1:pfra_pkg::PAGE_SHIFT];
      res_addr_r   <= '0;
      res_status_r <= pfra_pkg::ST_OK;
    end
    if (cmd.init_prep) begin
      stop_r <= {1'b0, first_r} + {1'b0, span_r};
    end
    if (cmd.scan_step) begin
      rd_idx_r <= scan_idx_r;
      if (scan_idx_r != '0) scan_idx_r <= scan_idx_r - 1'b1;
    end
    if (scan_hit) begin
      res_addr_r <= BASE_ADDRESS + (pfra_pkg::ADDR_W'(rd_idx_r) << pfra_pkg::PAGE_SHIFT);
    end
    if (scan_miss) begin
      res_status_r <= pfra_pkg::ST_NOMEM;
    end
    if (cmd.rmw_chk) begin
      idx_r      <= page_off[pfra_pkg::PAGE_SHIFT +: IDX_W];
      range_ok_r <= in_range;
    end
    if (cmd.rmw_wr) begin
      res_status_r <= rmw_status;
    end
    if (cmd.out_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
      out_free_r   <= free_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;
  assign out_free_count     = out_free_r;

`ifndef SYNTHESIS
  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> slot_free)
    else $error("result loaded over an untaken result");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_scan_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(scan_hit && scan_miss))
    else $error("scan reports both hit and miss");

  a_addr_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != pfra_pkg::ST_OK)) |-> (out_addr_r == '0))
    else $error("nonzero address on failed request");
`endif

endmodule

>>> rtl/core/page_frame_refcount_allocator.sv
// Page frame allocator with an 8-bit reference count for each 4 KB frame, PAGES
// frames from BASE_ADDRESS up. Opcode 0 (init) marks every frame used (count 100)
// and frees the frames from region_start for (region_end - region_start) >> 12
// frames; 1 (allocate) takes the highest free frame, sets its count to 1 and
// returns its address, or status 1 and address 0 when none is free; 2 (free)
// drops one reference; 3 (share) adds one, saturating at 255. Free and share on
// an address below BASE_ADDRESS, above region_end or past the last frame change
// nothing and return status 2. Every result carries the number of free frames,
// modulo 4096. Timing: the counts live in one single-port-write, one-read memory
// with a registered read, and every operation goes through it one count per
// cycle. Free and share go through the steps take, check and read, write, load.
// Allocate scans the counts downward one per cycle, examining at most PAGES
// counts. Init rewrites every count. After reset the block writes the used mark
// into every count before it takes a request; configuration writes are taken at
// any time. One request is in work at a time, but the next one is taken while
// the previous result still waits in the output register.
`timescale 1ns / 1ps

module page_frame_refcount_allocator #(
  parameter int unsigned PAGES        = 3840,
  parameter logic [31:0] BASE_ADDRESS = 32'd1048576
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pfra_req_if.sink                        in_req,
  pfra_rsp_if.source                      out_rsp,
  input  logic                            cfg_we,
  input  logic [pfra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfra_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pfra_pkg::cmd_t    cmd;
  pfra_pkg::sts_t    sts;
  pfra_pkg::op_t     in_opcode;
  pfra_pkg::status_t out_status;

  // Decode the request opcode once for both halves.
  assign in_opcode = pfra_pkg::op_t'(in_req.opcode);

  // Sequence each request: clear after reset, sweep for init, scan for
  // allocate, read-modify-write for free and share, then hold for the output.
  pfra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_opcode (in_opcode),
    .in_ready  (in_req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Count memory, free counter, configuration and the output register.
  pfra_dp #(
    .PAGES        (PAGES),
    .BASE_ADDRESS (BASE_ADDRESS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_page_address    (in_req.page_address),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_ready          (out_rsp.ready),
    .out_valid          (out_rsp.valid),
    .out_result_address (out_rsp.result_address),
    .out_status         (out_status),
    .out_free_count     (out_rsp.free_count)
  );

  assign out_rsp.status = out_status;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Match the DUT defaults: 3840 frames of 4 KB starting at 1 MB.
  localparam int unsigned FRAME_COUNT = 3840;
  localparam logic [31:0] FRAME_BASE  = 32'h0010_0000;
  // Cycles without any handshake before the run is declared hung. The longest
  // legal silence is a full scan or init sweep, plus both stalls.
  localparam int unsigned HANG_LIMIT  = 40000;
  // Settle time after the last result before a register write or the end.
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [31:0]       result_address;
    pfra_pkg::status_t status;
    logic [11:0]       free_count;
  } frame_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pfra_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pfra_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pfra_req_if req_ch ();
  pfra_rsp_if rsp_ch ();

  page_frame_refcount_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch.sink),
    .out_rsp   (rsp_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the allocator: per-frame counts, free total and both registers.
  logic [7:0]  frame_refs [FRAME_COUNT];
  logic [11:0] free_frames;
  logic [31:0] region_lo;
  logic [31:0] region_hi;

  frame_result_t pending_results[$];

  int errors = 0;
  int requests_sent;
  int results_checked = 0;
  int op_seen [4];
  int status_seen [8] = '{default: 0};
  int idle_cycles;
  int stall_left;
  bit no_stall;

  // Clock: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  // Map an address to a managed frame; reject below base, above the region end
  // and past the last frame.
  function automatic bit frame_index(input logic [31:0] addr, output int idx);
    logic [31:0] frame;
    idx = 0;
    if (addr < FRAME_BASE || addr > region_hi) return 1'b0;
    frame = (addr - FRAME_BASE) >> 12;
    if (frame >= FRAME_COUNT) return 1'b0;
    idx = int'(frame);
    return 1'b1;
  endfunction

  // Highest frame with a zero count, or -1 when memory is full.
  function automatic int highest_free_frame();
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (frame_refs[i] == 8'd0) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow state and return the answer it must give.
  function automatic frame_result_t predict_frame_op(input pfra_pkg::op_t op,
                                                     input logic [31:0] addr);
    frame_result_t r;
    logic [31:0]   first;
    logic [31:0]   span;
    logic [31:0]   iu;
    int            idx;
    r.result_address = 32'd0;
    r.status         = pfra_pkg::ST_OK;
    case (op)
      pfra_pkg::OP_INIT: begin
        // Mark everything used, then clear the configured window (mod 2^32 math).
        free_frames = 12'd0;
        first = (region_lo - FRAME_BASE) >> 12;
        span  = (region_hi - region_lo) >> 12;
        for (int i = 0; i < FRAME_COUNT; i++) begin
          iu = 32'(i);
          frame_refs[i] = pfra_pkg::USED_MARK;
          if (iu >= first && (iu - first) < span) begin
            frame_refs[i] = 8'd0;
            free_frames++;
          end
        end
      end
      pfra_pkg::OP_ALLOC: begin
        idx = highest_free_frame();
        if (idx < 0) begin
          r.status = pfra_pkg::ST_NOMEM;
        end else begin
          frame_refs[idx] = 8'd1;
          free_frames--;
          r.result_address = FRAME_BASE + (32'(idx) << 12);
        end
      end
      pfra_pkg::OP_FREE: begin
        if (!frame_index(addr, idx)) begin
          r.status = pfra_pkg::ST_IGNORED;
        end else if (frame_refs[idx] == 8'd0) begin
          r.status = pfra_pkg::ST_DOUBLE_FREE;
        end else begin
          frame_refs[idx]--;
          if (frame_refs[idx] == 8'd0) free_frames++;
        end
      end
      default: begin
        if (!frame_index(addr, idx)) begin
          r.status = pfra_pkg::ST_IGNORED;
        end else if (frame_refs[idx] == pfra_pkg::CNT_MAX) begin
          r.status = pfra_pkg::ST_SATURATED;
        end else begin
          if (frame_refs[idx] == 8'd0) free_frames--;
          frame_refs[idx]++;
        end
      end
    endcase
    r.free_count = free_frames;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drive one request, hold it until accepted, then record its expected answer.
  // Leave valid high afterwards so back-to-back requests need no second NBA.
  task automatic send_request(input pfra_pkg::op_t op, input logic [31:0] addr);
    int gap;
    if (!no_stall && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.page_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(predict_frame_op(op, addr));
    requests_sent++;
    op_seen[op]++;
  endtask

  // Drop valid, drain every outstanding result and let the block settle.
  task automatic drain_requests();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one region register while the block is idle.
  task automatic write_region(input logic [pfra_pkg::CFG_IDX_W-1:0] idx,
                              input logic [31:0] value);
    drain_requests();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pfra_pkg::CFG_REGION_START) region_lo = value;
    else region_hi = value;
  endtask

  task automatic set_region(input logic [31:0] lo, input logic [31:0] hi);
    write_region(pfra_pkg::CFG_REGION_START, lo);
    write_region(pfra_pkg::CFG_REGION_END, hi);
  endtask

  function automatic logic [31:0] frame_addr(input int idx);
    return FRAME_BASE + (32'(idx) << 12);
  endfunction

  // Pick a frame address biased toward the top, where the free window lives.
  function automatic logic [31:0] pick_target();
    int idx;
    if ($urandom_range(0, 3) != 0) idx = $urandom_range(FRAME_COUNT - 64, FRAME_COUNT - 1);
    else idx = $urandom_range(0, FRAME_COUNT - 1);
    return frame_addr(idx) + 32'($urandom_range(0, 4095));
  endfunction

  // Window of the top n frames, with a random end flavor.
  task automatic set_top_window(input int n);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = frame_addr(FRAME_COUNT - n);
    case ($urandom_range(0, 3))
      0: hi = 32'hFFFF_FFFF;
      1: hi = lo + 32'(n << 12) - 32'($urandom_range(1, 8192));
      default: hi = lo + 32'(n << 12);
    endcase
    set_region(lo + 32'($urandom_range(0, 4095)), hi);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset window is empty: nothing to allocate, used frames only move by one.
  task automatic test_empty_region();
    send_request(pfra_pkg::OP_INIT, 32'hFFFF_FFFF);
    send_request(pfra_pkg::OP_ALLOC, 32'h0000_0000);
    send_request(pfra_pkg::OP_FREE, FRAME_BASE);
    send_request(pfra_pkg::OP_SHARE, FRAME_BASE);
    send_request(pfra_pkg::OP_FREE, 32'h0000_0000);
    send_request(pfra_pkg::OP_SHARE, 32'hFFFF_FFFF);
    send_request(pfra_pkg::OP_FREE, FRAME_BASE + 32'h0000_0FFF);
  endtask

  // Four free frames at the top: drain them, run out, then double free and
  // share a free frame.
  task automatic test_top_region();
    set_region(frame_addr(FRAME_COUNT - 4), frame_addr(FRAME_COUNT));
    send_request(pfra_pkg::OP_INIT, 32'h0000_0000);
    repeat (4) send_request(pfra_pkg::OP_ALLOC, $urandom());
    send_request(pfra_pkg::OP_ALLOC, $urandom());
    send_request(pfra_pkg::OP_FREE, frame_addr(FRAME_COUNT - 1));
    send_request(pfra_pkg::OP_FREE, frame_addr(FRAME_COUNT - 1));
    send_request(pfra_pkg::OP_SHARE, frame_addr(FRAME_COUNT - 1));
  endtask

  // Register extremes, addresses just outside the managed range.
  task automatic test_region_extremes();
    write_region(pfra_pkg::CFG_REGION_END, 32'hFFFF_FFFF);
    send_request(pfra_pkg::OP_SHARE, frame_addr(FRAME_COUNT));
    send_request(pfra_pkg::OP_FREE, FRAME_BASE - 32'd1);
    set_region(32'h0000_0000, 32'h0000_0000);
    send_request(pfra_pkg::OP_INIT, 32'h0000_0000);
    set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(pfra_pkg::OP_INIT, 32'hFFFF_FFFF);
    set_region(FRAME_BASE, 32'hFFFF_FFFF);
    send_request(pfra_pkg::OP_INIT, 32'h5555_5555);
    send_request(pfra_pkg::OP_ALLOC, 32'hAAAA_AAAA);
    send_request(pfra_pkg::OP_FREE, FRAME_BASE);
    send_request(pfra_pkg::OP_SHARE, FRAME_BASE);
    write_region(pfra_pkg::CFG_REGION_END, 32'h0000_0000);
    send_request(pfra_pkg::OP_FREE, frame_addr(FRAME_COUNT - 1));
  endtask

  // Pile references on one allocated frame until the count saturates.
  task automatic test_saturation();
    set_region(frame_addr(FRAME_COUNT - 8), frame_addr(FRAME_COUNT));
    send_request(pfra_pkg::OP_INIT, $urandom());
    send_request(pfra_pkg::OP_ALLOC, $urandom());
    repeat (260) send_request(pfra_pkg::OP_SHARE,
                              frame_addr(FRAME_COUNT - 1) + 32'($urandom_range(0, 4095)));
    repeat (3) send_request(pfra_pkg::OP_FREE, frame_addr(FRAME_COUNT - 1));
  endtask

  // Rounds of init followed by a mix of allocate, free, share and noise.
  task automatic test_random_mix(input int rounds, input int ops_per_round);
    int  roll;
    bit  cheap_alloc;
    for (int r = 0; r < rounds; r++) begin
      // Mostly a small window at the top; now and then arbitrary registers.
      if ($urandom_range(0, 7) == 0) set_region($urandom(), $urandom());
      else set_top_window($urandom_range(1, 48));
      send_request(pfra_pkg::OP_INIT, $urandom());
      for (int k = 0; k < ops_per_round; k++) begin
        roll = $urandom_range(0, 99);
        // Hold allocates back when the scan would walk most of the table.
        cheap_alloc = highest_free_frame() >= int'(FRAME_COUNT) - 256;
        if (roll < 30) begin
          if (cheap_alloc || $urandom_range(0, 29) == 0) begin
            send_request(pfra_pkg::OP_ALLOC, $urandom());
          end else begin
            send_request(pfra_pkg::OP_SHARE, pick_target());
          end
        end else if (roll < 60) begin
          send_request(pfra_pkg::OP_FREE, pick_target());
        end else if (roll < 85) begin
          send_request(pfra_pkg::OP_SHARE, pick_target());
        end else if (roll < 97) begin
          send_request(pfra_pkg::op_t'($urandom_range(2, 3)), $urandom());
        end else begin
          send_request(pfra_pkg::OP_INIT, $urandom());
        end
      end
    end
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_quiet_tail();
    drain_requests();
    no_stall = 1'b1;
    test_random_mix(1, 40);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result addr=%h status=%0d free=%0d", $time,
                 rsp_ch.result_address, rsp_ch.status, rsp_ch.free_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_seen[rsp_ch.status]++;
        if (rsp_ch.result_address !== want.result_address) begin
          $display("%0t: result_address expected %h got %h", $time,
                   want.result_address, rsp_ch.result_address);
          errors++;
        end
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.free_count !== want.free_count) begin
          $display("%0t: free_count expected %0d got %0d", $time,
                   want.free_count, rsp_ch.free_count);
          errors++;
        end
      end
    end
  end

  // Result-side backpressure in random bursts; none in the tail.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (no_stall) begin
      rsp_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Hang detection: count cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, pending_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    requests_sent   = 0;
    no_stall        = 1'b0;
    foreach (op_seen[i]) op_seen[i] = 0;

    // Start every input at a known value and reset the shadow state.
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = pfra_pkg::CFG_REGION_START;
    cfg_wdata           = 32'd0;
    req_ch.valid        = 1'b0;
    req_ch.opcode       = pfra_pkg::OP_INIT;
    req_ch.page_address = 32'd0;
    foreach (frame_refs[i]) frame_refs[i] = pfra_pkg::USED_MARK;
    free_frames = 12'd0;
    region_lo   = pfra_pkg::CFG_RESET_VALUE;
    region_hi   = pfra_pkg::CFG_RESET_VALUE;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // The first request waits out the clearing pass on its own handshake.
    test_empty_region();
    test_top_region();
    test_region_extremes();
    test_saturation();
    test_random_mix(20, 40);
    test_quiet_tail();

    drain_requests();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests: %0d init, %0d allocate, %0d free, %0d share;",
             requests_sent, op_seen[pfra_pkg::OP_INIT], op_seen[pfra_pkg::OP_ALLOC],
             op_seen[pfra_pkg::OP_FREE], op_seen[pfra_pkg::OP_SHARE]);
    $display("checked %0d results: ok %0d, out of memory %0d, ignored %0d, %s %0d, %s %0d",
             results_checked, status_seen[pfra_pkg::ST_OK], status_seen[pfra_pkg::ST_NOMEM],
             status_seen[pfra_pkg::ST_IGNORED], "double free",
             status_seen[pfra_pkg::ST_DOUBLE_FREE], "saturated",
             status_seen[pfra_pkg::ST_SATURATED]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
